// ===== rtl/core/pbdde_pkg.sv =====
package pbdde_pkg;

  localparam int unsigned NumBinsDefault = 1024;
  localparam int unsigned TapW           = 32;
  localparam logic signed [15:0] TapOne  = 16'sd4096;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;

  localparam logic [15:0] AdaptGainRst = 16'd655;
  localparam logic [14:0] DecLevelRst  = 15'd2896;
  localparam logic [19:0] RegularRst   = 20'd16777;

  localparam int unsigned X3W  = 21;
  localparam int unsigned SqW  = 41;
  localparam int unsigned DenW = 42;
  localparam int unsigned NumW = 46;
  localparam int unsigned CmpW = DenW + 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAdaptGain   = 2'd0,
    CfgDecLevel    = 2'd1,
    CfgRegularizer = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OpEqualize = 1'b0,
    OpLoadTap  = 1'b1
  } op_e;

  typedef struct packed {
    op_e                    op;
    logic signed [15:0]     xr;
    logic signed [15:0]     xi;
    logic signed [15:0]     wr;
    logic signed [15:0]     wi;
    logic signed [31:0]     p0;
    logic signed [31:0]     p1;
    logic signed [31:0]     p2;
    logic signed [31:0]     p3;
    logic signed [15:0]     x1r;
    logic signed [15:0]     x1i;
    logic signed [X3W-1:0]  x3r;
    logic signed [X3W-1:0]  x3i;
    logic [SqW-1:0]         sqr;
    logic [SqW-1:0]         sqi;
    logic                   sr;
    logic                   si;
    logic [X3W-1:0]         magr;
    logic [X3W-1:0]         magi;
    logic [DenW-1:0]        den;
    logic                   dz;
    logic [NumW-1:0]        nr;
    logic [NumW-1:0]        ni;
    logic                   ovr;
    logic                   ovi;
    logic [15:0]            qr;
    logic [15:0]            qi;
    logic signed [33:0]     gr;
    logic signed [33:0]     gi;
    logic signed [15:0]     tr;
    logic signed [15:0]     ti;
    logic signed [15:0]     er;
    logic signed [15:0]     ei;
  } pl_t;

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    logic signed [15:0] r;
    if (v > 48'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -48'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/pbdde_in_if.sv =====
interface pbdde_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [9:0]  bin_index;
  logic signed [15:0] sample_re;
  logic signed [15:0] sample_im;

  modport source (output valid, output op, output bin_index, output sample_re,
                  output sample_im, input ready);
  modport sink (input valid, input op, input bin_index, input sample_re,
                input sample_im, output ready);
endinterface

// ===== rtl/core/pbdde_out_if.sv =====
interface pbdde_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] eq_re;
  logic signed [15:0] eq_im;

  modport source (output valid, output eq_re, output eq_im, input ready);
  modport sink (input valid, input eq_re, input eq_im, output ready);
endinterface

// ===== rtl/core/pbdde_ram.sv =====
module pbdde_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/per_bin_decision_directed_eq.sv =====
// An accepted word moves through the registered stages pipe_q[0] to pipe_q[Last] before its result is shown.
// Throughput: one word per cycle while the output is not stalled; a word whose bin is still
// in the pipeline waits until that earlier word has left it, an interlock on the tap memory
// read-modify-write.
// Reset: control and configuration registers take their defaults, then a sweep over all NumBins
// bins writes every tap to 1.0 while the input is not ready.
module per_bin_decision_directed_eq
  import pbdde_pkg::NumBinsDefault, pbdde_pkg::CfgIdxW, pbdde_pkg::CfgDataW;
#(
  parameter int unsigned NumBins = NumBinsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  pbdde_in_if.sink            samp_i,
  pbdde_out_if.source         res_o
);
  import pbdde_pkg::*;

  localparam int unsigned AddrW   = (NumBins > 1) ? $clog2(NumBins) : 1;
  localparam int unsigned Last    = 28;
  localparam int unsigned WrStage = 25;
  localparam int unsigned DivLo   = 9;
  localparam int unsigned DivHi   = 24;

  logic [15:0] gain_q;
  logic [14:0] level_q;
  logic [19:0] reg_q;

  pl_t              pipe_q [Last+1];
  pl_t              pipe_d [Last+1];
  logic [Last:0]    v_q;
  logic [AddrW-1:0] bin_q [Last+1];

  logic             clr_q;
  logic [AddrW-1:0] clr_cnt_q;

  logic             adv, hit, in_range, accept;
  logic [AddrW-1:0] in_addr;
  logic [TapW-1:0]  rd_tap;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [TapW-1:0]  ram_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= AdaptGainRst;
      level_q <= DecLevelRst;
      reg_q   <= RegularRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgAdaptGain:   gain_q  <= cfg_data_i[15:0];
        CfgDecLevel:    level_q <= cfg_data_i[14:0];
        CfgRegularizer: reg_q   <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  assign in_addr  = AddrW'(samp_i.bin_index);
  assign in_range = 32'(samp_i.bin_index) < NumBins;
  assign adv      = !(v_q[Last] && (pipe_q[Last].op == OpEqualize) && !res_o.ready);

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i <= Last; i++) begin
      if (v_q[i] && (bin_q[i] == in_addr)) begin
        hit = 1'b1;
      end
    end
  end

  assign samp_i.ready = !clr_q && adv && !hit;
  assign accept       = samp_i.valid && samp_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + AddrW'(1);
      if (clr_cnt_q == AddrW'(NumBins - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  assign ram_we    = clr_q || (v_q[WrStage] && adv);
  assign ram_waddr = clr_q ? clr_cnt_q : bin_q[WrStage];
  assign ram_wdata = clr_q ? {16'sd0, TapOne} :
                     {pipe_d[WrStage+1].ti, pipe_d[WrStage+1].tr};

  pbdde_ram #(
    .Width (TapW),
    .Depth (NumBins)
  ) u_tap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (rd_tap)
  );

  function automatic logic signed [15:0] x5_of(input logic [15:0] q, input logic ov,
                                               input logic neg, input logic dz);
    logic signed [15:0] r;
    if (dz) begin
      r = '0;
    end else if (!neg) begin
      r = (ov || q[15]) ? 16'sh7fff : $signed(q);
    end else begin
      r = (ov || (q > 16'd32768)) ? 16'sh8000 : -$signed(q);
    end
    return r;
  endfunction

  always_comb begin
    logic signed [32:0] s0, s1;
    logic signed [41:0] sq0, sq1;
    logic signed [15:0] lvl, x2r, x2i, x5r, x5i;
    logic signed [16:0] dr, di;
    logic signed [17:0] rg0, rg1;
    logic [CmpW-1:0]    dk;

    pipe_d[0]      = '0;
    pipe_d[0].op   = op_e'(samp_i.op);
    pipe_d[0].xr   = samp_i.sample_re;
    pipe_d[0].xi   = samp_i.sample_im;
    for (int i = 1; i <= Last; i++) begin
      pipe_d[i] = pipe_q[i-1];
    end

    pipe_d[1].wr = (pipe_q[0].op == OpLoadTap) ? pipe_q[0].xr : $signed(rd_tap[15:0]);
    pipe_d[1].wi = (pipe_q[0].op == OpLoadTap) ? pipe_q[0].xi : $signed(rd_tap[31:16]);
    pipe_d[1].p0 = pipe_q[0].xr * $signed(rd_tap[15:0]);
    pipe_d[1].p1 = pipe_q[0].xi * $signed(rd_tap[31:16]);
    pipe_d[1].p2 = pipe_q[0].xi * $signed(rd_tap[15:0]);
    pipe_d[1].p3 = pipe_q[0].xr * $signed(rd_tap[31:16]);

    s0 = 33'(pipe_q[1].p0) - 33'(pipe_q[1].p1);
    s1 = 33'(pipe_q[1].p2) + 33'(pipe_q[1].p3);
    pipe_d[2].x1r = sat16(48'((s0 + 33'sd2048) >>> 12));
    pipe_d[2].x1i = sat16(48'((s1 + 33'sd2048) >>> 12));

    lvl = $signed({1'b0, level_q});
    x2r = (pipe_q[2].x1r > 16'sd0) ? lvl : -lvl;
    x2i = (pipe_q[2].x1i > 16'sd0) ? lvl : -lvl;
    pipe_d[3].p0 = pipe_q[2].x1r * x2r;
    pipe_d[3].p1 = pipe_q[2].x1i * x2i;
    pipe_d[3].p2 = pipe_q[2].x1i * x2r;
    pipe_d[3].p3 = pipe_q[2].x1r * x2i;

    s0 = 33'(pipe_q[3].p0) + 33'(pipe_q[3].p1);
    s1 = 33'(pipe_q[3].p2) - 33'(pipe_q[3].p3);
    pipe_d[4].x3r = X3W'((s0 + 33'sd2048) >>> 12);
    pipe_d[4].x3i = X3W'((s1 + 33'sd2048) >>> 12);

    sq0 = pipe_q[4].x3r * pipe_q[4].x3r;
    sq1 = pipe_q[4].x3i * pipe_q[4].x3i;
    pipe_d[5].sqr = sq0[SqW-1:0];
    pipe_d[5].sqi = sq1[SqW-1:0];

    pipe_d[6].den  = DenW'(pipe_q[5].sqr) + DenW'(pipe_q[5].sqi) + DenW'(reg_q);
    pipe_d[6].sr   = pipe_q[5].x3r[X3W-1];
    pipe_d[6].si   = !pipe_q[5].x3i[X3W-1];
    pipe_d[6].magr = pipe_q[5].x3r[X3W-1] ? X3W'(-pipe_q[5].x3r) : X3W'(pipe_q[5].x3r);
    pipe_d[6].magi = pipe_q[5].x3i[X3W-1] ? X3W'(-pipe_q[5].x3i) : X3W'(pipe_q[5].x3i);

    pipe_d[7].nr = (NumW'(pipe_q[6].magr) << 24) + NumW'(pipe_q[6].den >> 1);
    pipe_d[7].ni = (NumW'(pipe_q[6].magi) << 24) + NumW'(pipe_q[6].den >> 1);
    pipe_d[7].dz = (pipe_q[6].den == '0);

    dk = CmpW'(pipe_q[7].den) << 16;
    pipe_d[8].ovr = CmpW'(pipe_q[7].nr) >= dk;
    pipe_d[8].ovi = CmpW'(pipe_q[7].ni) >= dk;
    pipe_d[8].qr  = '0;
    pipe_d[8].qi  = '0;

    // restoring divide, one quotient bit per stage, MSB first
    for (int i = DivLo; i <= DivHi; i++) begin
      dk = CmpW'(pipe_q[i-1].den) << (DivHi - i);
      if (CmpW'(pipe_q[i-1].nr) >= dk) begin
        pipe_d[i].nr = NumW'(CmpW'(pipe_q[i-1].nr) - dk);
        pipe_d[i].qr = {pipe_q[i-1].qr[14:0], 1'b1};
      end else begin
        pipe_d[i].qr = {pipe_q[i-1].qr[14:0], 1'b0};
      end
      if (CmpW'(pipe_q[i-1].ni) >= dk) begin
        pipe_d[i].ni = NumW'(CmpW'(pipe_q[i-1].ni) - dk);
        pipe_d[i].qi = {pipe_q[i-1].qi[14:0], 1'b1};
      end else begin
        pipe_d[i].qi = {pipe_q[i-1].qi[14:0], 1'b0};
      end
    end

    x5r = x5_of(pipe_q[24].qr, pipe_q[24].ovr, pipe_q[24].sr, pipe_q[24].dz);
    x5i = x5_of(pipe_q[24].qi, pipe_q[24].ovi, pipe_q[24].si, pipe_q[24].dz);
    dr  = 17'(x5r) - 17'(pipe_q[24].wr);
    di  = 17'(x5i) - 17'(pipe_q[24].wi);
    pipe_d[25].gr = dr * $signed({1'b0, gain_q});
    pipe_d[25].gi = di * $signed({1'b0, gain_q});

    rg0 = 18'((pipe_q[25].gr + 34'sd32768) >>> 16);
    rg1 = 18'((pipe_q[25].gi + 34'sd32768) >>> 16);
    if (pipe_q[25].op == OpLoadTap) begin
      pipe_d[26].tr = pipe_q[25].wr;
      pipe_d[26].ti = pipe_q[25].wi;
    end else begin
      pipe_d[26].tr = sat16(48'(pipe_q[25].wr) + 48'(rg0));
      pipe_d[26].ti = sat16(48'(pipe_q[25].wi) + 48'(rg1));
    end

    pipe_d[27].p0 = pipe_q[26].x1r * pipe_q[26].tr;
    pipe_d[27].p1 = pipe_q[26].x1i * pipe_q[26].ti;
    pipe_d[27].p2 = pipe_q[26].x1i * pipe_q[26].tr;
    pipe_d[27].p3 = pipe_q[26].x1r * pipe_q[26].ti;

    s0 = 33'(pipe_q[27].p0) - 33'(pipe_q[27].p1);
    s1 = 33'(pipe_q[27].p2) + 33'(pipe_q[27].p3);
    pipe_d[28].er = sat16(48'((s0 + 33'sd2048) >>> 12));
    pipe_d[28].ei = sat16(48'((s1 + 33'sd2048) >>> 12));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[Last-1:0], accept && in_range};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pipe_q[0] <= pipe_d[0];
      bin_q[0]  <= in_addr;
      for (int i = 1; i <= Last; i++) begin
        pipe_q[i] <= pipe_d[i];
        bin_q[i]  <= bin_q[i-1];
      end
    end
  end

  assign res_o.valid = v_q[Last] && (pipe_q[Last].op == OpEqualize);
  assign res_o.eq_re = pipe_q[Last].er;
  assign res_o.eq_im = pipe_q[Last].ei;

`ifndef SYNTH
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !samp_i.ready)
    else $error("word accepted during tap clear");

  a_pipe_empty_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> (v_q == '0))
    else $error("pipeline busy during tap clear");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_range) |=> v_q[0])
    else $error("accepted word lost at pipeline entry");

  a_no_same_bin_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && v_q[WrStage]) |-> (bin_q[WrStage] != in_addr))
    else $error("tap read overlaps pending write to same bin");
`endif

endmodule
